// File: rtl/rlr_pkg.sv
// Shared constants for the record log ring: sizes, operation and status codes.
`timescale 1ns / 1ps
`default_nettype none
package rlr_pkg;
   localparam int RING_BYTES_DEF = 1024;
   localparam int HEADER_BYTES = 10;
   localparam int SUM_W = 18;
   localparam int LEN_W = 16;
   localparam int SEQ_W = 64;

   localparam logic [2:0] OP_APPEND_START = 3'd0;
   localparam logic [2:0] OP_APPEND_BYTE = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_READ_RESTART = 3'd3;
   localparam logic [2:0] OP_READ_NEXT = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_NOTHING = 2'd2;
   localparam logic [1:0] ST_OUT_OF_SEQ = 2'd3;
endpackage
`default_nettype wire

// File: rtl/rlr_ram.sv
// Byte-wide ring store with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rlr_ram #(
   parameter int DEPTH = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/record_log_ring.sv
// Top level of the record log ring: command sequencer around the ring store.
`timescale 1ns / 1ps
`default_nettype none
// Each request gives exactly one response. An append start evicts head records
// until the new record fits or the ring is empty. The ten header bytes are
// written one a cycle through the single store write port. A read restart and
// a read next that opens a new record fetch the length field from the store
// one byte a cycle. A read next that opens a zero-length record returns no
// payload byte. Sequence numbers of held records are consecutive, so the
// oldest sequence comes from the counter and the live count.
module record_log_ring
   import rlr_pkg::*;
#(
   parameter int RING_BYTES = rlr_pkg::RING_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [15:0] req_record_length,
   input  wire logic [7:0]  req_payload_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_live_count,
   output logic             rsp_is_empty,
   output logic [63:0]      rsp_oldest_seq,
   output logic [63:0]      rsp_newest_seq,
   output logic [63:0]      rsp_assigned_seq,
   output logic [7:0]       rsp_read_byte,
   output logic [9:0]       rsp_read_rec_length,
   output logic             rsp_read_last
);
   localparam int PW = $clog2(RING_BYTES);
   localparam int UW = $clog2(RING_BYTES + 1);
   localparam int CW = $clog2(RING_BYTES / HEADER_BYTES + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_EVCHK = 4'd1;
   localparam logic [3:0] S_L0 = 4'd2;
   localparam logic [3:0] S_L1 = 4'd3;
   localparam logic [3:0] S_L2 = 4'd4;
   localparam logic [3:0] S_HDR = 4'd5;
   localparam logic [3:0] S_BRD = 4'd6;
   localparam logic [3:0] S_BCAP = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p,
                                          input logic [SUM_W-1:0] n);
      logic [SUM_W-1:0] s;
      s = SUM_W'(p) + n;
      if (s >= SUM_W'(RING_BYTES)) begin
         s = s - SUM_W'(RING_BYTES);
      end
      return s[PW-1:0];
   endfunction

   logic [3:0]       state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [PW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [SEQ_W-1:0] next_ff, next_in;
   logic             open_ff, open_in;
   logic [LEN_W-1:0] arem_ff, arem_in, alen_ff, alen_in;
   logic [UW-1:0]    aoff_ff, aoff_in;
   logic [PW-1:0]    cursor_ff, cursor_in;
   logic [LEN_W-1:0] rrem_ff, rrem_in, rlen_ff, rlen_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [SEQ_W-1:0] rnseq_ff, rnseq_in, rcseq_ff, rcseq_in;
   logic             evicted_ff, evicted_in;
   logic [PW-1:0]    lbase_ff, lbase_in;
   logic [7:0]       lo_ff, lo_in;
   logic [3:0]       hk_ff, hk_in;
   logic [1:0]       status_ff, status_in;
   logic [SEQ_W-1:0] aseq_ff, aseq_in;
   logic [7:0]       rbyte_ff, rbyte_in;
   logic [9:0]       orlen_ff, orlen_in;
   logic             rlast_ff, rlast_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       o_status_ff;
   logic [6:0]       o_live_ff;
   logic             o_empty_ff;
   logic [63:0]      o_oldest_ff, o_newest_ff, o_aseq_ff;
   logic [7:0]       o_rbyte_ff;
   logic [9:0]       o_rlen_ff;
   logic             o_rlast_ff;
   logic             load_out;

   logic             wr_en;
   logic [PW-1:0]    wr_addr, rd_addr;
   logic [7:0]       wr_data, rd_data;

   logic [SEQ_W-1:0] oldest;
   logic [SUM_W-1:0] need, fsz, used_left;
   logic [LEN_W-1:0] len_rd;

   rlr_ram #(.DEPTH(RING_BYTES), .ADDR_W(PW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign oldest = next_ff - SEQ_W'(count_ff);
   assign need = SUM_W'(HEADER_BYTES) + SUM_W'(len_ff);
   assign len_rd = {rd_data, lo_ff};
   assign fsz = SUM_W'(HEADER_BYTES) + SUM_W'(len_rd);
   assign used_left = SUM_W'(used_ff) - fsz;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      len_in = len_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      used_in = used_ff;
      count_in = count_ff;
      next_in = next_ff;
      open_in = open_ff;
      arem_in = arem_ff;
      alen_in = alen_ff;
      aoff_in = aoff_ff;
      cursor_in = cursor_ff;
      rrem_in = rrem_ff;
      rlen_in = rlen_ff;
      left_in = left_ff;
      rnseq_in = rnseq_ff;
      rcseq_in = rcseq_ff;
      evicted_in = evicted_ff;
      lbase_in = lbase_ff;
      lo_in = lo_ff;
      hk_in = hk_ff;
      status_in = status_ff;
      aseq_in = aseq_ff;
      rbyte_in = rbyte_ff;
      orlen_in = orlen_ff;
      rlast_in = rlast_ff;
      wr_en = 1'b0;
      wr_addr = wrap(tail_ff, SUM_W'(aoff_ff));
      wr_data = req_payload_byte;
      rd_addr = cursor_ff;
      load_out = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               len_in = req_record_length;
               status_in = ST_OK;
               aseq_in = '0;
               rbyte_in = '0;
               orlen_in = '0;
               rlast_in = 1'b0;
               evicted_in = 1'b0;
               state_in = S_DONE;
               case (req_op)
                  OP_APPEND_START: begin
                     if (SUM_W'(req_record_length) >
                         SUM_W'(RING_BYTES - HEADER_BYTES)) begin
                        status_in = ST_TOO_LARGE;
                     end else begin
                        state_in = S_EVCHK;
                     end
                  end
                  OP_APPEND_BYTE: begin
                     if (!open_ff || arem_ff == '0) begin
                        status_in = ST_OUT_OF_SEQ;
                     end else begin
                        wr_en = 1'b1;
                        aseq_in = next_ff;
                        arem_in = arem_ff - 1'b1;
                        aoff_in = aoff_ff + 1'b1;
                        if (arem_ff == LEN_W'(1)) begin
                           tail_in = wrap(tail_ff, SUM_W'(HEADER_BYTES) + SUM_W'(alen_ff));
                           used_in = UW'(SUM_W'(used_ff) + SUM_W'(HEADER_BYTES)
                                         + SUM_W'(alen_ff));
                           count_in = count_ff + 1'b1;
                           next_in = next_ff + 1'b1;
                           open_in = 1'b0;
                           arem_in = '0;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     head_in = '0;
                     tail_in = '0;
                     used_in = '0;
                     count_in = '0;
                     open_in = 1'b0;
                     arem_in = '0;
                     rrem_in = '0;
                     left_in = '0;
                  end
                  OP_READ_RESTART: begin
                     cursor_in = head_ff;
                     left_in = count_ff;
                     rrem_in = '0;
                     rnseq_in = oldest;
                     if (count_ff != '0) begin
                        aseq_in = oldest;
                        lbase_in = head_ff;
                        state_in = S_L0;
                     end
                  end
                  OP_READ_NEXT: begin
                     if (rrem_ff != '0) begin
                        state_in = S_BRD;
                     end else if (left_ff == '0) begin
                        status_in = ST_NOTHING;
                     end else begin
                        lbase_in = cursor_ff;
                        state_in = S_L0;
                     end
                  end
                  default: begin
                     status_in = ST_OUT_OF_SEQ;
                  end
               endcase
            end
         end
         S_EVCHK: begin
            if (SUM_W'(used_ff) + need > SUM_W'(RING_BYTES) && count_ff != '0) begin
               lbase_in = head_ff;
               state_in = S_L0;
            end else begin
               if (evicted_ff) begin
                  rrem_in = '0;
                  left_in = '0;
               end
               hk_in = '0;
               state_in = S_HDR;
            end
         end
         S_L0: begin
            rd_addr = wrap(lbase_ff, SUM_W'(8));
            state_in = S_L1;
         end
         S_L1: begin
            lo_in = rd_data;
            rd_addr = wrap(lbase_ff, SUM_W'(9));
            state_in = S_L2;
         end
         S_L2: begin
            case (op_ff)
               OP_APPEND_START: begin
                  evicted_in = 1'b1;
                  if (fsz > SUM_W'(used_ff)) begin
                     head_in = tail_ff;
                     used_in = '0;
                     count_in = '0;
                  end else begin
                     head_in = wrap(head_ff, fsz);
                     used_in = used_left[UW-1:0];
                     count_in = count_ff - 1'b1;
                  end
                  state_in = S_EVCHK;
               end
               OP_READ_RESTART: begin
                  orlen_in = len_rd[9:0];
                  state_in = S_DONE;
               end
               default: begin
                  rrem_in = len_rd;
                  rlen_in = len_rd;
                  cursor_in = wrap(cursor_ff, SUM_W'(HEADER_BYTES));
                  rcseq_in = rnseq_ff;
                  rnseq_in = rnseq_ff + 1'b1;
                  aseq_in = rnseq_ff;
                  if (len_rd == '0) begin
                     rlast_in = 1'b1;
                     left_in = left_ff - 1'b1;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_BRD;
                  end
               end
            endcase
         end
         S_HDR: begin
            wr_en = 1'b1;
            wr_addr = wrap(tail_ff, SUM_W'(hk_ff));
            if (hk_ff < 4'd8) begin
               wr_data = next_ff[{hk_ff[2:0], 3'b000} +: 8];
            end else if (hk_ff == 4'd8) begin
               wr_data = len_ff[7:0];
            end else begin
               wr_data = len_ff[15:8];
            end
            hk_in = hk_ff + 1'b1;
            if (hk_ff == 4'd9) begin
               aseq_in = next_ff;
               if (len_ff == '0) begin
                  tail_in = wrap(tail_ff, SUM_W'(HEADER_BYTES));
                  used_in = UW'(SUM_W'(used_ff) + SUM_W'(HEADER_BYTES));
                  count_in = count_ff + 1'b1;
                  next_in = next_ff + 1'b1;
                  open_in = 1'b0;
                  arem_in = '0;
               end else begin
                  open_in = 1'b1;
                  arem_in = len_ff;
                  alen_in = len_ff;
                  aoff_in = UW'(HEADER_BYTES);
               end
               state_in = S_DONE;
            end
         end
         S_BRD: begin
            rd_addr = cursor_ff;
            state_in = S_BCAP;
         end
         S_BCAP: begin
            aseq_in = rcseq_ff;
            orlen_in = rlen_ff[9:0];
            rbyte_in = rd_data;
            cursor_in = wrap(cursor_ff, SUM_W'(1));
            rrem_in = rrem_ff - 1'b1;
            if (rrem_ff == LEN_W'(1)) begin
               rlast_in = 1'b1;
               left_in = left_ff - 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         used_ff <= '0;
         count_ff <= '0;
         next_ff <= SEQ_W'(1);
         open_ff <= 1'b0;
         arem_ff <= '0;
         cursor_ff <= '0;
         rrem_ff <= '0;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         used_ff <= used_in;
         count_ff <= count_in;
         next_ff <= next_in;
         open_ff <= open_in;
         arem_ff <= arem_in;
         cursor_ff <= cursor_in;
         rrem_ff <= rrem_in;
         left_ff <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      len_ff <= len_in;
      alen_ff <= alen_in;
      aoff_ff <= aoff_in;
      rlen_ff <= rlen_in;
      rnseq_ff <= rnseq_in;
      rcseq_ff <= rcseq_in;
      evicted_ff <= evicted_in;
      lbase_ff <= lbase_in;
      lo_ff <= lo_in;
      hk_ff <= hk_in;
      status_ff <= status_in;
      aseq_ff <= aseq_in;
      rbyte_ff <= rbyte_in;
      orlen_ff <= orlen_in;
      rlast_ff <= rlast_in;
      if (load_out) begin
         o_status_ff <= status_ff;
         o_live_ff <= 7'(32'(count_ff));
         o_empty_ff <= (count_ff == '0);
         o_oldest_ff <= (count_ff != '0) ? oldest : '0;
         o_newest_ff <= (count_ff != '0) ? next_ff - 1'b1 : '0;
         o_aseq_ff <= aseq_ff;
         o_rbyte_ff <= rbyte_ff;
         o_rlen_ff <= orlen_ff;
         o_rlast_ff <= rlast_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = o_status_ff;
   assign rsp_live_count = o_live_ff;
   assign rsp_is_empty = o_empty_ff;
   assign rsp_oldest_seq = o_oldest_ff;
   assign rsp_newest_seq = o_newest_ff;
   assign rsp_assigned_seq = o_aseq_ff;
   assign rsp_read_byte = o_rbyte_ff;
   assign rsp_read_rec_length = o_rlen_ff;
   assign rsp_read_last = o_rlast_ff;
endmodule
`default_nettype wire

// File: test/tb_record_log_ring.sv
// Self-checking testbench for the record log ring, with a built-in predictor and random stalls.
`timescale 1ns / 1ps
module tb_record_log_ring;
   import rlr_pkg::*;

   localparam int RING = 1024;
   localparam int TARGET_ITEMS = 550;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] len;
      logic [7:0]  pbyte;
   } ring_cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  live;
      logic        empty;
      logic [63:0] oldest;
      logic [63:0] newest;
      logic [63:0] aseq;
      logic [7:0]  rbyte;
      logic [9:0]  rlen;
      logic        rlast;
   } ring_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_op = '0;
   logic [15:0] req_record_length = '0;
   logic [7:0] req_payload_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ring_rsp_type got;

   record_log_ring u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_record_length(req_record_length), .req_payload_byte(req_payload_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(got.status),
      .rsp_live_count(got.live), .rsp_is_empty(got.empty), .rsp_oldest_seq(got.oldest),
      .rsp_newest_seq(got.newest), .rsp_assigned_seq(got.aseq),
      .rsp_read_byte(got.rbyte), .rsp_read_rec_length(got.rlen),
      .rsp_read_last(got.rlast)
   );

   always #10 clock = ~clock;

   ring_cmd_type pending_cmds[$];
   ring_rsp_type expected_rsps[$];
   int errors = 0;
   int rsp_count = 0;
   bit stall_mode = 1'b0;

   // Predictor state.
   logic [7:0] ring_mem [RING];
   int unsigned head_p = 0, tail_p = 0, used = 0, count = 0;
   int unsigned app_rem = 0, rd_cur = 0, rd_rem = 0, rd_left = 0, rd_hdr = 0;
   bit app_open = 1'b0;
   logic [63:0] seq_ctr = 64'd1;

   function automatic int unsigned wrap(int unsigned p, int unsigned n);
      return (p + n) % RING;
   endfunction

   function automatic logic [63:0] hdr_seq(int unsigned p);
      logic [63:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) s[8*i +: 8] = ring_mem[wrap(p, i)];
      return s;
   endfunction

   function automatic int unsigned hdr_len(int unsigned p);
      return {ring_mem[wrap(p, 9)], ring_mem[wrap(p, 8)]};
   endfunction

   task automatic commit_record(int unsigned len);
      tail_p = wrap(tail_p, HEADER_BYTES + len);
      used += HEADER_BYTES + len;
      count++;
      seq_ctr++;
      app_open = 1'b0;
      app_rem = 0;
   endtask

   task automatic predict_ring(input ring_cmd_type c, output ring_rsp_type r);
      int unsigned fsz, rl;
      bit evicted;
      r = '0;
      r.status = ST_OK;
      case (c.op)
         OP_APPEND_START: begin
            if (c.len > RING - HEADER_BYTES) begin
               r.status = ST_TOO_LARGE;
            end else begin
               evicted = 1'b0;
               while (used + HEADER_BYTES + c.len > RING && count > 0) begin
                  fsz = HEADER_BYTES + hdr_len(head_p);
                  evicted = 1'b1;
                  if (fsz > used) begin
                     head_p = tail_p;
                     used = 0;
                     count = 0;
                     break;
                  end
                  head_p = wrap(head_p, fsz);
                  used -= fsz;
                  count--;
               end
               if (evicted) begin
                  rd_rem = 0;
                  rd_left = 0;
               end
               r.aseq = seq_ctr;
               for (int i = 0; i < 8; i++) ring_mem[wrap(tail_p, i)] = seq_ctr[8*i +: 8];
               ring_mem[wrap(tail_p, 8)] = c.len[7:0];
               ring_mem[wrap(tail_p, 9)] = c.len[15:8];
               if (c.len == 0) begin
                  commit_record(0);
               end else begin
                  app_open = 1'b1;
                  app_rem = c.len;
               end
            end
         end
         OP_APPEND_BYTE: begin
            if (!app_open || app_rem == 0) begin
               r.status = ST_OUT_OF_SEQ;
            end else begin
               rl = hdr_len(tail_p);
               ring_mem[wrap(tail_p, HEADER_BYTES + rl - app_rem)] = c.pbyte;
               r.aseq = seq_ctr;
               app_rem--;
               if (app_rem == 0) commit_record(rl);
            end
         end
         OP_CLEAR: begin
            head_p = 0;
            tail_p = 0;
            used = 0;
            count = 0;
            app_open = 1'b0;
            app_rem = 0;
            rd_rem = 0;
            rd_left = 0;
         end
         OP_READ_RESTART: begin
            rd_cur = head_p;
            rd_hdr = head_p;
            rd_left = count;
            rd_rem = 0;
            if (count > 0) begin
               r.aseq = hdr_seq(head_p);
               r.rlen = 10'(hdr_len(head_p));
            end
         end
         OP_READ_NEXT: begin
            if (rd_rem == 0 && rd_left == 0) begin
               r.status = ST_NOTHING;
            end else begin
               if (rd_rem == 0) begin
                  rd_hdr = rd_cur;
                  rd_rem = hdr_len(rd_cur);
                  rd_cur = wrap(rd_cur, HEADER_BYTES);
               end
               r.aseq = hdr_seq(rd_hdr);
               if (rd_rem == 0) begin
                  r.rlast = 1'b1;
                  rd_left--;
               end else begin
                  r.rlen = 10'(hdr_len(rd_hdr));
                  r.rbyte = ring_mem[rd_cur];
                  rd_cur = wrap(rd_cur, 1);
                  rd_rem--;
                  if (rd_rem == 0) begin
                     r.rlast = 1'b1;
                     rd_left--;
                  end
               end
            end
         end
         default: r.status = ST_OUT_OF_SEQ;
      endcase
      r.live = count[6:0];
      r.empty = (count == 0);
      r.oldest = count > 0 ? hdr_seq(head_p) : 64'd0;
      r.newest = count > 0 ? seq_ctr - 64'd1 : 64'd0;
   endtask

   task automatic add_cmd(input logic [2:0] op, input int len, input int pb);
      ring_cmd_type c;
      c.op = op;
      c.len = 16'(len);
      c.pbyte = 8'(pb);
      pending_cmds.push_back(c);
   endtask

   task automatic add_record(input int len, input int sent);
      add_cmd(OP_APPEND_START, len, $urandom);
      for (int i = 0; i < sent; i++) add_cmd(OP_APPEND_BYTE, $urandom, $urandom_range(0, 255));
   endtask

   function automatic int draw_wait();
      return stall_mode ? $urandom_range(0, 19) : 0;
   endfunction

   // Driver: presents queued commands at the falling edge.
   bit req_taken = 1'b0, rsp_taken = 1'b0;
   int req_gap = 0, rsp_gap = 0;
   int rsp_wait;
   ring_cmd_type next_cmd;

   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_cmds.size() > 0) begin
         next_cmd = pending_cmds.pop_front();
         req_op <= next_cmd.op;
         req_record_length <= next_cmd.len;
         req_payload_byte <= next_cmd.pbyte;
         req_valid <= 1'b1;
         req_gap <= draw_wait();
      end else begin
         req_valid <= 1'b0;
      end

      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_taken) begin
         rsp_wait = draw_wait();
         rsp_ready <= (rsp_wait == 0);
         rsp_gap <= (rsp_wait > 0) ? rsp_wait - 1 : 0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predicts on each command transfer and checks each response transfer.
   always @(posedge clock) begin
      ring_cmd_type c;
      ring_rsp_type e;
      req_taken <= req_valid && req_ready && !reset;
      rsp_taken <= rsp_valid && rsp_ready && !reset;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected response transfer: %p", got);
         end else begin
            e = expected_rsps.pop_front();
            if (got.status !== e.status || got.live !== e.live || got.empty !== e.empty ||
                got.oldest !== e.oldest || got.newest !== e.newest ||
                got.aseq !== e.aseq || got.rbyte !== e.rbyte || got.rlen !== e.rlen ||
                got.rlast !== e.rlast) begin
               errors++;
               if (errors <= 10) $display("Mismatch: expected %p, actual %p", e, got);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         c.op = req_op;
         c.len = req_record_length;
         c.pbyte = req_payload_byte;
         predict_ring(c, e);
         expected_rsps.push_back(e);
      end
   end

   initial begin
      int kind, len, sent, n, total_cmds;
      bit long_done;
      long_done = 1'b0;

      // Directed part.
      add_cmd(OP_READ_NEXT, 0, 0);
      add_cmd(OP_APPEND_BYTE, 0, 8'hFF);
      add_cmd(3'd5, 0, 0);
      add_cmd(3'd6, 16'hFFFF, 8'hFF);
      add_cmd(3'd7, 0, 0);
      add_cmd(OP_APPEND_START, 0, 0);
      add_cmd(OP_APPEND_START, 3, 0);
      add_cmd(OP_APPEND_BYTE, 0, 8'h00);
      add_cmd(OP_APPEND_START, RING - HEADER_BYTES + 1, 0);
      add_cmd(OP_APPEND_BYTE, 0, 8'hFF);
      add_cmd(OP_APPEND_BYTE, 0, 8'hA5);
      add_cmd(OP_APPEND_START, 16'hFFFF, 0);
      add_cmd(OP_READ_RESTART, 0, 0);
      add_cmd(OP_APPEND_START, 2, 0);
      add_cmd(OP_APPEND_BYTE, 0, 8'h5A);
      add_cmd(OP_APPEND_START, 1, 0);
      add_cmd(OP_APPEND_BYTE, 0, 8'h3C);
      for (int i = 0; i < 6; i++) add_cmd(OP_READ_NEXT, 0, 0);
      add_cmd(OP_CLEAR, 0, 0);
      add_cmd(OP_READ_RESTART, 0, 0);

      // Random part: mostly complete records and read sweeps.
      while (pending_cmds.size() < TARGET_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (!long_done && pending_cmds.size() > TARGET_ITEMS / 2) begin
            long_done = 1'b1;
            add_record(RING - HEADER_BYTES, 4);
            add_cmd(OP_READ_NEXT, 0, 0);
            add_cmd(OP_CLEAR, 0, 0);
         end else if (kind < 55) begin
            n = $urandom_range(0, 99);
            len = n < 70 ? $urandom_range(0, 8) :
                  n < 96 ? $urandom_range(9, 60) : $urandom_range(61, 300);
            sent = $urandom_range(0, 9) == 0 ? $urandom_range(0, len) : len;
            add_record(len, sent);
         end else if (kind < 75) begin
            add_cmd(OP_READ_RESTART, 0, 0);
            n = $urandom_range(1, 25);
            for (int i = 0; i < n; i++) add_cmd(OP_READ_NEXT, 0, 0);
         end else if (kind < 82) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) add_cmd(OP_READ_NEXT, 0, 0);
         end else if (kind < 85) begin
            add_cmd(OP_CLEAR, 0, 0);
         end else if (kind < 92) begin
            add_cmd(OP_APPEND_START, $urandom_range(RING - HEADER_BYTES + 1, 65535), 0);
         end else if (kind < 96) begin
            add_cmd($urandom_range(0, 1) ? OP_APPEND_BYTE : 3'($urandom_range(5, 7)),
                    $urandom, $urandom);
         end else begin
            len = $urandom_range(2, 12);
            add_record(len, $urandom_range(0, len - 1));
         end
      end
      total_cmds = pending_cmds.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (rsp_count >= total_cmds);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0 && rsp_count == total_cmds) begin
         $display("** record_log_ring: PASSED **");
      end else begin
         $display("** record_log_ring: FAILED **");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("** record_log_ring: FAILED **");
      $finish;
   end
endmodule

// File: sim.f
rtl/rlr_pkg.sv
rtl/rlr_ram.sv
rtl/record_log_ring.sv
test/tb_record_log_ring.sv
